>>> hdl/crfg_pkg.sv
package crfg_pkg;

  localparam int DIM_W     = 14;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = DIM_W + FRAC_W;
  localparam int DIV_Q_W   = DIM_W;
  localparam int DIV_LAT   = DIV_Q_W + 1;
  localparam int PIPE_LAT  = 2 * DIV_LAT + 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(8192);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_CROP_MODE    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] pw;
    logic [DIM_W-1:0] ph;
    logic             inval;
  } side_a_t;

  typedef struct packed {
    logic [DIM_W-1:0] dx;
    logic [DIM_W-1:0] dy;
    logic [DIM_W-1:0] dw;
    logic [DIM_W-1:0] dh;
    logic [DIM_W-1:0] pw;
    logic [DIM_W-1:0] ph;
    logic             inval;
  } side_b_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  function automatic logic [DIM_W-1:0] min_dim(input logic [DIM_W-1:0] a,
                                               input logic [DIM_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

>>> hdl/crfg_div.sv
module crfg_div import crfg_pkg::*; (
  input  logic                clk,
  input  logic [PROD_W-1:0]   num,
  input  logic [FRAC_W-1:0]   den,
  output logic [DIV_Q_W-1:0]  quot
);

  logic [PROD_W-1:0]  rem_r [0:DIV_Q_W];
  logic [FRAC_W-1:0]  den_r [0:DIV_Q_W];
  logic [DIV_Q_W-1:0] q_r   [0:DIV_Q_W];
  logic               sat_r [0:DIV_Q_W];
  logic [PROD_W-1:0]  trial [0:DIV_Q_W-1];
  logic               ge    [0:DIV_Q_W-1];

  always_comb begin
    for (int s = 0; s < DIV_Q_W; s++) begin
      trial[s] = PROD_W'(den_r[s]) << (DIV_Q_W - 1 - s);
      ge[s]    = rem_r[s] >= trial[s];
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    den_r[0] <= den;
    q_r[0]   <= '0;
    sat_r[0] <= num >= {den, {DIV_Q_W{1'b0}}};
    for (int s = 0; s < DIV_Q_W; s++) begin
      rem_r[s+1] <= ge[s] ? (rem_r[s] - trial[s]) : rem_r[s];
      den_r[s+1] <= den_r[s];
      sat_r[s+1] <= sat_r[s];
      q_r[s+1]   <= q_r[s] | (DIV_Q_W'(ge[s]) << (DIV_Q_W - 1 - s));
    end
  end

  assign quot = sat_r[DIV_Q_W] ? '1 : q_r[DIV_Q_W];

endmodule

>>> hdl/compositor_region_fit_geometry.sv
// Region fit geometry: source and destination rectangles for one picture.
// Configuration: cfg_we writes cfg_data into register cfg_index (frame
// width, frame height, crop mode); write only while no request is in flight.
// Input: a request is taken at each clock edge with start high and busy low.
// busy is high only during reset and the first cycle after it, so a new
// request may be issued on every cycle.
// Output: each result shows on the out_ ports for one cycle with out_valid
// high, in request order.
// Throughput: one request per cycle. The path runs through two chains of
// restoring dividers (an input register and 14 stages, one
// quotient bit each), plus four stages for products, clipping and the fit.
// Reset: clears out_valid and the pipeline valid bits and loads 1920 x 1080, letterbox mode.
// The receiver cannot hold results off and needs no flow control.
module compositor_region_fit_geometry import crfg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic [FRAC_W-1:0]    in_left_num,
  input  logic [FRAC_W-1:0]    in_left_den,
  input  logic [FRAC_W-1:0]    in_top_num,
  input  logic [FRAC_W-1:0]    in_top_den,
  input  logic [FRAC_W-1:0]    in_span_w_num,
  input  logic [FRAC_W-1:0]    in_span_w_den,
  input  logic [FRAC_W-1:0]    in_span_h_num,
  input  logic [FRAC_W-1:0]    in_span_h_den,
  input  logic [DIM_W-1:0]     in_pic_width,
  input  logic [DIM_W-1:0]     in_pic_height,
  output logic                 out_valid,
  output logic [DIM_W-1:0]     out_src_left,
  output logic [DIM_W-1:0]     out_src_top,
  output logic [DIM_W-1:0]     out_src_w,
  output logic [DIM_W-1:0]     out_src_h,
  output logic [DIM_W-1:0]     out_dst_left,
  output logic [DIM_W-1:0]     out_dst_top,
  output logic [DIM_W-1:0]     out_dst_w,
  output logic [DIM_W-1:0]     out_dst_h,
  output logic                 out_valid_res
);

  logic [DIM_W-1:0] frame_w_r, frame_h_r;
  logic             crop_r, busy_r;
  logic [DIM_W-1:0] fw, fh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= DIM_W'(1920);
      frame_h_r <= DIM_W'(1080);
      crop_r    <= 1'b0;
      busy_r    <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_w_r <= cfg_data;
          REG_FRAME_HEIGHT: frame_h_r <= cfg_data;
          REG_CROP_MODE:    crop_r    <= cfg_data[0];
          default:          ;
        endcase
      end
    end
  end

  assign busy = busy_r;
  assign fw   = sat_dim(frame_w_r);
  assign fh   = sat_dim(frame_h_r);

  // stage 0: scale fractions by frame size
  logic                v0_r;
  logic [PROD_W-1:0]   nx_r, ny_r, nw_r, nh_r;
  logic [FRAC_W-1:0]   ldx_r, ldy_r, ldw_r, ldh_r;
  side_a_t             sa0_r;
  logic [PROD_W-1:0]   prod_x, prod_y, prod_w, prod_h;

  assign prod_x = PROD_W'(fw) * PROD_W'(in_left_num);
  assign prod_y = PROD_W'(fh) * PROD_W'(in_top_num);
  assign prod_w = PROD_W'(fw) * PROD_W'(in_span_w_num);
  assign prod_h = PROD_W'(fh) * PROD_W'(in_span_h_num);

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= start && !busy_r;
    nx_r  <= prod_x;
    ny_r  <= prod_y;
    nw_r  <= prod_w;
    nh_r  <= prod_h;
    ldx_r <= in_left_den;
    ldy_r <= in_top_den;
    ldw_r <= in_span_w_den;
    ldh_r <= in_span_h_den;
    sa0_r.pw    <= sat_dim(in_pic_width);
    sa0_r.ph    <= sat_dim(in_pic_height);
    sa0_r.inval <= (in_left_den == '0) || (in_top_den == '0) ||
                   (in_span_w_den == '0) || (in_span_h_den == '0) ||
                   (in_pic_width == '0) || (in_pic_height == '0);
  end

  logic [DIV_Q_W-1:0] qx, qy, qw, qh;

  crfg_div u_div_x (.clk(clk), .num(nx_r), .den(ldx_r), .quot(qx));
  crfg_div u_div_y (.clk(clk), .num(ny_r), .den(ldy_r), .quot(qy));
  crfg_div u_div_w (.clk(clk), .num(nw_r), .den(ldw_r), .quot(qw));
  crfg_div u_div_h (.clk(clk), .num(nh_r), .den(ldh_r), .quot(qh));

  logic    va_r [0:DIV_LAT-1];
  side_a_t sa_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) va_r[i] <= 1'b0;
    end else begin
      va_r[0] <= v0_r;
      for (int i = 1; i < DIV_LAT; i++) va_r[i] <= va_r[i-1];
    end
    sa_r[0] <= sa0_r;
    for (int i = 1; i < DIV_LAT; i++) sa_r[i] <= sa_r[i-1];
  end

  // stage 1: saturate position, clip size at frame edge
  logic             v1_r;
  side_b_t          s1_r;
  logic [DIM_W-1:0] dx1, dy1;
  logic [DIM_W:0]   sum_x, sum_y;

  assign dx1   = min_dim(qx, fw);
  assign dy1   = min_dim(qy, fh);
  assign sum_x = {1'b0, dx1} + {1'b0, qw};
  assign sum_y = {1'b0, dy1} + {1'b0, qh};

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= va_r[DIV_LAT-1];
    s1_r.dx    <= dx1;
    s1_r.dy    <= dy1;
    s1_r.dw    <= (sum_x > {1'b0, fw}) ? (fw - dx1) : qw;
    s1_r.dh    <= (sum_y > {1'b0, fh}) ? (fh - dy1) : qh;
    s1_r.pw    <= sa_r[DIV_LAT-1].pw;
    s1_r.ph    <= sa_r[DIV_LAT-1].ph;
    s1_r.inval <= sa_r[DIV_LAT-1].inval;
  end

  // stage 2: cross products for the aspect fit
  logic              v2_r;
  side_b_t           s2_r;
  side_b_t           s1_chk;
  logic [PROD_W-1:0] na_r, nb_r;
  logic [FRAC_W-1:0] da_r, db_r;

  always_comb begin
    s1_chk       = s1_r;
    s1_chk.inval = s1_r.inval ||
                   (crop_r && ((s1_r.dw == '0) || (s1_r.dh == '0)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    s2_r <= s1_chk;
    if (crop_r) begin
      na_r <= PROD_W'(s1_r.dw) * PROD_W'(s1_r.ph);
      da_r <= FRAC_W'(s1_r.dh);
      nb_r <= PROD_W'(s1_r.dh) * PROD_W'(s1_r.pw);
      db_r <= FRAC_W'(s1_r.dw);
    end else begin
      na_r <= PROD_W'(s1_r.pw) * PROD_W'(s1_r.dh);
      da_r <= FRAC_W'(s1_r.ph);
      nb_r <= PROD_W'(s1_r.ph) * PROD_W'(s1_r.dw);
      db_r <= FRAC_W'(s1_r.pw);
    end
  end

  logic [DIV_Q_W-1:0] qa, qb;

  crfg_div u_div_a (.clk(clk), .num(na_r), .den(da_r), .quot(qa));
  crfg_div u_div_b (.clk(clk), .num(nb_r), .den(db_r), .quot(qb));

  logic    vb_r [0:DIV_LAT-1];
  side_b_t sb_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) vb_r[i] <= 1'b0;
    end else begin
      vb_r[0] <= v2_r;
      for (int i = 1; i < DIV_LAT; i++) vb_r[i] <= vb_r[i-1];
    end
    sb_r[0] <= s2_r;
    for (int i = 1; i < DIV_LAT; i++) sb_r[i] <= sb_r[i-1];
  end

  // stage 3: fit, center, clear the low bit to make values even
  side_b_t          sf;
  logic [DIM_W-1:0] sx, sy, sw, sh, cw, ch, px, py;
  logic [DIM_W-1:0] even_m;

  assign sf     = sb_r[DIV_LAT-1];
  assign even_m = ~DIM_W'(1);

  always_comb begin
    if (crop_r) begin
      sw = min_dim(sf.pw, qa);
      sh = min_dim(sf.ph, qb);
      sx = (sf.pw - sw) >> 1;
      sy = (sf.ph - sh) >> 1;
      cw = sf.dw;
      ch = sf.dh;
    end else begin
      sw = sf.pw;
      sh = sf.ph;
      sx = '0;
      sy = '0;
      cw = min_dim(sf.dw, qa);
      ch = min_dim(sf.dh, qb);
    end
    px = sf.dx + ((sf.dw - cw) >> 1);
    py = sf.dy + ((sf.dh - ch) >> 1);
  end

  logic             out_valid_r, res_ok_r;
  logic [DIM_W-1:0] src_left_r, src_top_r, src_w_r, src_h_r;
  logic [DIM_W-1:0] dst_left_r, dst_top_r, dst_w_r, dst_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= vb_r[DIV_LAT-1];
    if (sf.inval) begin
      res_ok_r   <= 1'b0;
      src_left_r <= '0;
      src_top_r  <= '0;
      src_w_r    <= '0;
      src_h_r    <= '0;
      dst_left_r <= '0;
      dst_top_r  <= '0;
      dst_w_r    <= '0;
      dst_h_r    <= '0;
    end else begin
      res_ok_r   <= 1'b1;
      src_left_r <= sx & even_m;
      src_top_r  <= sy & even_m;
      src_w_r    <= sw & even_m;
      src_h_r    <= sh & even_m;
      dst_left_r <= px & even_m;
      dst_top_r  <= py & even_m;
      dst_w_r    <= cw & even_m;
      dst_h_r    <= ch & even_m;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = res_ok_r;
  assign out_src_left  = src_left_r;
  assign out_src_top   = src_top_r;
  assign out_src_w     = src_w_r;
  assign out_src_h     = src_h_r;
  assign out_dst_left  = dst_left_r;
  assign out_dst_top   = dst_top_r;
  assign out_dst_w     = dst_w_r;
  assign out_dst_h     = dst_h_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(start && !busy, PIPE_LAT))
    else $error("result strobe does not match request latency");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |->
      (out_src_left == '0 && out_src_top == '0 && out_src_w == '0 &&
       out_src_h == '0 && out_dst_left == '0 && out_dst_top == '0 &&
       out_dst_w == '0 && out_dst_h == '0))
    else $error("invalid result carries nonzero geometry");

  a_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      !(out_src_left[0] | out_src_top[0] | out_src_w[0] | out_src_h[0] |
        out_dst_left[0] | out_dst_top[0] | out_dst_w[0] | out_dst_h[0]))
    else $error("odd coordinate in result");

endmodule
